@@ src/pdrs_pkg.sv @@
// Shared types and constants for the PWM duty ramp sequencer.
`default_nettype none
package pdrs_pkg;

    localparam int DUTY_W = 7;
    localparam int TIME_W = 32;
    localparam int TOP_W  = 16;
    localparam int IDX_W  = 3;

    typedef enum logic [1:0] {
        PH_DWELL = 2'd0,
        PH_UP    = 2'd1,
        PH_DOWN  = 2'd2
    } t_phase;

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_DUTY_LOW   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DUTY_HIGH  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_STEP_SIZE  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_DWELL_MS   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_STEP_IVL   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_PERIOD_TOP = 3'd5;

    // Reset values
    localparam logic [DUTY_W-1:0] RST_DUTY_LOW   = 7'd12;
    localparam logic [DUTY_W-1:0] RST_DUTY_HIGH  = 7'd48;
    localparam logic [DUTY_W-1:0] RST_STEP_SIZE  = 7'd5;
    localparam logic [TIME_W-1:0] RST_DWELL_MS   = 32'd5000;
    localparam logic [TIME_W-1:0] RST_STEP_IVL   = 32'd1000;
    localparam logic [TOP_W-1:0]  RST_PERIOD_TOP = 16'd33332;

    localparam logic [DUTY_W-1:0] DUTY_SAT = 7'd100;

    // floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^23
    localparam int               RECIP_SHIFT = 30;
    localparam logic [23:0]      RECIP_100   = 24'd10737419;
    localparam int               PROD_W      = 23;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_low;
        logic [DUTY_W-1:0] duty_high;
        logic [DUTY_W-1:0] step_size;
        logic [TIME_W-1:0] dwell_ms;
        logic [TIME_W-1:0] step_ivl_ms;
        logic [TOP_W-1:0]  period_top;
    } t_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        t_phase            phase;
        logic              updated;
    } t_ramp_res;

endpackage
`default_nettype wire

@@ src/pdrs_ramp.sv @@
// Ramp state machine: dwell, ramp up, ramp down, one timestamp per enable.
`default_nettype none
module pdrs_ramp (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_en,
    input  wire [pdrs_pkg::TIME_W-1:0] i_now_ms,
    input  wire pdrs_pkg::t_cfg        i_cfg,
    output pdrs_pkg::t_ramp_res        o_res
);

    pdrs_pkg::t_phase                r_phase, n_phase;
    logic [pdrs_pkg::TIME_W-1:0]     r_last_ms, n_last_ms;
    logic [pdrs_pkg::DUTY_W-1:0]     r_duty, n_duty;
    logic                            n_updated;
    pdrs_pkg::t_ramp_res             r_res;

    logic [pdrs_pkg::TIME_W-1:0]     w_elapsed;
    logic                            w_dwell_done;
    logic                            w_step_due;
    logic [pdrs_pkg::DUTY_W:0]       w_sum;
    logic signed [pdrs_pkg::DUTY_W+1:0] w_diff;
    logic signed [pdrs_pkg::DUTY_W+1:0] w_low_s;

    assign w_elapsed    = i_now_ms - r_last_ms;   // wraps mod 2^32
    assign w_dwell_done = (w_elapsed >= i_cfg.dwell_ms);
    assign w_step_due   = (w_elapsed >= i_cfg.step_ivl_ms);
    assign w_sum        = {1'b0, r_duty} + {1'b0, i_cfg.step_size};
    assign w_diff       = $signed({2'b00, r_duty}) - $signed({2'b00, i_cfg.step_size});
    assign w_low_s      = $signed({2'b00, i_cfg.duty_low});

    always_comb begin
        n_phase   = r_phase;
        n_last_ms = r_last_ms;
        n_duty    = r_duty;
        n_updated = 1'b0;
        case (r_phase)
            pdrs_pkg::PH_DWELL: begin
                if (w_dwell_done) begin
                    n_phase   = pdrs_pkg::PH_UP;
                    n_last_ms = i_now_ms;
                end
            end
            pdrs_pkg::PH_UP: begin
                if (w_step_due) begin
                    n_last_ms = i_now_ms;
                    n_updated = 1'b1;
                    if (w_sum >= {1'b0, i_cfg.duty_high}) begin
                        n_duty  = i_cfg.duty_high;
                        n_phase = pdrs_pkg::PH_DOWN;
                    end else begin
                        n_duty = w_sum[pdrs_pkg::DUTY_W-1:0];
                    end
                end
            end
            pdrs_pkg::PH_DOWN: begin
                if (w_step_due) begin
                    n_last_ms = i_now_ms;
                    n_updated = 1'b1;
                    if (w_diff <= w_low_s) begin
                        n_duty  = i_cfg.duty_low;
                        n_phase = pdrs_pkg::PH_DWELL;
                    end else begin
                        n_duty = w_diff[pdrs_pkg::DUTY_W-1:0];
                    end
                end
            end
            default: begin
                n_phase = pdrs_pkg::PH_DWELL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pdrs_pkg::PH_DWELL;
            r_last_ms <= '0;
            r_duty    <= pdrs_pkg::RST_DUTY_LOW;
        end else if (i_en) begin
            r_phase   <= n_phase;
            r_last_ms <= n_last_ms;
            r_duty    <= n_duty;
        end
    end

    // result register, payload only
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.duty    <= n_duty;
            r_res.phase   <= n_phase;
            r_res.updated <= n_updated;
        end
    end

    assign o_res = r_res;

    // state moves only on a processed beat
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_phase) && $stable(r_last_ms) && $stable(r_duty))
        else $error("ramp state changed without a beat");

    // dwell is only left towards ramp up
    a_dwell_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pdrs_pkg::PH_DWELL |=>
            r_phase == pdrs_pkg::PH_DWELL || r_phase == pdrs_pkg::PH_UP)
        else $error("dwell left towards ramp down");

    // ramp up is only left towards ramp down
    a_up_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == pdrs_pkg::PH_UP |=>
            r_phase == pdrs_pkg::PH_UP || r_phase == pdrs_pkg::PH_DOWN)
        else $error("ramp up left towards dwell");

endmodule
`default_nettype wire

@@ src/pdrs_cmp.sv @@
// Compare value: saturated duty times (top+1), divided by 100 via reciprocal.
`default_nettype none
module pdrs_cmp (
    input  wire                        i_clk,
    input  wire                        i_en,
    input  wire pdrs_pkg::t_ramp_res   i_res,
    input  wire [pdrs_pkg::TOP_W-1:0]  i_period_top,
    output pdrs_pkg::t_ramp_res        o_res,
    output logic [pdrs_pkg::TOP_W-1:0] o_compare
);

    localparam int QW = pdrs_pkg::PROD_W + 24;

    logic [pdrs_pkg::DUTY_W-1:0]  w_dsat;
    logic [pdrs_pkg::TOP_W:0]     w_top1;
    logic [23:0]                  w_prod;
    logic [QW-1:0]                w_qfull;
    logic [pdrs_pkg::TOP_W:0]     w_q;

    logic [pdrs_pkg::PROD_W-1:0]  r_prod;
    pdrs_pkg::t_ramp_res          r_res_s2;
    pdrs_pkg::t_ramp_res          r_res_s3;
    logic [pdrs_pkg::TOP_W-1:0]   r_compare;

    assign w_dsat = (i_res.duty > pdrs_pkg::DUTY_SAT) ? pdrs_pkg::DUTY_SAT : i_res.duty;
    assign w_top1 = {1'b0, i_period_top} + 17'd1;
    assign w_prod = 24'(w_dsat) * 24'(w_top1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= w_prod[pdrs_pkg::PROD_W-1:0];   // at most 100 * 2^16
            r_res_s2 <= i_res;
        end
    end

    assign w_qfull = QW'(r_prod) * QW'(pdrs_pkg::RECIP_100);
    assign w_q     = w_qfull[pdrs_pkg::RECIP_SHIFT +: (pdrs_pkg::TOP_W + 1)];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_compare <= w_q[pdrs_pkg::TOP_W] ? '1 : w_q[pdrs_pkg::TOP_W-1:0];
            r_res_s3  <= r_res_s2;
        end
    end

    assign o_res     = r_res_s3;
    assign o_compare = r_compare;

endmodule
`default_nettype wire

@@ src/pwm_duty_ramp_sequencer.sv @@
// Top level of the PWM duty ramp sequencer: ports, registers, pipeline control.
`default_nettype none
// Usage
//   Slave stream: one beat per millisecond timestamp, i_s_tdata = now_ms.
//   Master stream: one result beat per input beat, in order, carrying the
//   PWM compare value, the duty in whole percent, the ramp phase and a flag
//   that marks a step that wrote a new duty.
//   Configuration: plain write port, one register per cycle with
//   i_cfg_wr_en high; index 0..5 as listed in the package, others ignored.
//   Write only while no beat is in flight; new values apply to later beats.
// Timing
//   Four register stages: input register, ramp state update, product,
//   reciprocal divide into the output register; each accepted beat passes
//   them in order. One beat per cycle sustained unless the output stalls;
//   all stages move together on a single advance enable.
// Reset
//   Synchronous, active low: phase dwell, last event 0 ms, duty 12 percent,
//   registers back to their defaults, pipeline empty. No clearing pass.
// Backpressure
//   While the output beat waits on i_m_tready the whole pipe holds and
//   o_s_tready is low; the output register keeps its beat unchanged.
module pwm_duty_ramp_sequencer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // slave stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [31:0] now_ms
    // master stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [15:0] compare_value, [22:16] duty_percent,
                                     // [24:23] phase, [25] compare_updated, [31:26] zero
    // configuration
    input  wire         i_cfg_wr_en,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    pdrs_pkg::t_cfg               r_cfg;
    logic [pdrs_pkg::TIME_W-1:0]  r_now_ms;
    logic                         r_s0_v, r_s1_v, r_s2_v, r_out_v;
    logic                         w_adv;
    logic                         w_in_acc;

    pdrs_pkg::t_ramp_res          w_ramp_res;
    pdrs_pkg::t_ramp_res          w_out_res;
    logic [pdrs_pkg::TOP_W-1:0]   w_compare;

    // whole pipe advances when the output slot is free or being drained
    assign w_adv    = !r_out_v || i_m_tready;
    assign w_in_acc = i_s_tvalid && w_adv;

    assign o_s_tready = w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.duty_low    <= pdrs_pkg::RST_DUTY_LOW;
            r_cfg.duty_high   <= pdrs_pkg::RST_DUTY_HIGH;
            r_cfg.step_size   <= pdrs_pkg::RST_STEP_SIZE;
            r_cfg.dwell_ms    <= pdrs_pkg::RST_DWELL_MS;
            r_cfg.step_ivl_ms <= pdrs_pkg::RST_STEP_IVL;
            r_cfg.period_top  <= pdrs_pkg::RST_PERIOD_TOP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pdrs_pkg::CFG_DUTY_LOW:   r_cfg.duty_low    <= i_cfg_data[6:0];
                pdrs_pkg::CFG_DUTY_HIGH:  r_cfg.duty_high   <= i_cfg_data[6:0];
                pdrs_pkg::CFG_STEP_SIZE:  r_cfg.step_size   <= i_cfg_data[6:0];
                pdrs_pkg::CFG_DWELL_MS:   r_cfg.dwell_ms    <= i_cfg_data;
                pdrs_pkg::CFG_STEP_IVL:   r_cfg.step_ivl_ms <= i_cfg_data;
                pdrs_pkg::CFG_PERIOD_TOP: r_cfg.period_top  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_s0_v  <= i_s_tvalid;
            r_s1_v  <= r_s0_v;
            r_s2_v  <= r_s1_v;
            r_out_v <= r_s2_v;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now_ms <= i_s_tdata;
        end
    end

    // state only steps for a real beat, bubbles leave it alone
    pdrs_ramp u_ramp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv && r_s0_v),
        .i_now_ms (r_now_ms),
        .i_cfg    (r_cfg),
        .o_res    (w_ramp_res)
    );

    pdrs_cmp u_cmp (
        .i_clk        (i_clk),
        .i_en         (w_adv),
        .i_res        (w_ramp_res),
        .i_period_top (r_cfg.period_top),
        .o_res        (w_out_res),
        .o_compare    (w_compare)
    );

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {6'b0, w_out_res.updated, 2'(w_out_res.phase),
                         w_out_res.duty, w_compare};

    // a beat sitting in the input stage is never dropped by a stall
    a_s0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_v && !w_adv |=> r_s0_v)
        else $error("input stage beat lost during stall");

    // a beat in the product stage always moves into a free output register
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v && !r_out_v |=> r_out_v)
        else $error("output register not filled from product stage");

    // zero duty always gives a zero compare value
    a_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && (w_out_res.duty == '0) |-> (w_compare == '0))
        else $error("non-zero compare for zero duty");

endmodule
`default_nettype wire

@@ verif/pwm_duty_ramp_sequencer_test.sv @@
// Self-checking stream testbench for the PWM duty ramp sequencer.
module pwm_duty_ramp_sequencer_test;

    // Depth from acceptance to the output register; a little slack on top
    localparam int PIPE_LAT  = 3;
    localparam int MAX_GAP   = 13;
    localparam int N_PHASES  = 8;
    localparam int PER_PHASE = 50;
    localparam int N_ROWS    = 30;
    localparam int MAX_SHOWN = 10;

    // Indexes outside the register map; writes to them must be dropped
    localparam logic [pdrs_pkg::IDX_W-1:0] CFG_BAD_6 = 3'd6;
    localparam logic [pdrs_pkg::IDX_W-1:0] CFG_BAD_7 = 3'd7;
    // Filler index for beat rows
    localparam logic [pdrs_pkg::IDX_W-1:0] NO_IDX    = pdrs_pkg::CFG_DUTY_LOW;

    // Short phase names for the script table
    localparam pdrs_pkg::t_phase PHS_DWELL = pdrs_pkg::PH_DWELL;
    localparam pdrs_pkg::t_phase PHS_UP    = pdrs_pkg::PH_UP;
    localparam pdrs_pkg::t_phase PHS_DOWN  = pdrs_pkg::PH_DOWN;

    typedef enum bit {ROW_BEAT, ROW_WRITE} t_row_kind;

    // One result beat as the block should present it
    typedef struct packed {
        logic [pdrs_pkg::TOP_W-1:0]  cmp;
        logic [pdrs_pkg::DUTY_W-1:0] duty;
        pdrs_pkg::t_phase            ph;
        logic                        upd;
    } t_duty_res;

    // Directed script row: a beat (val = now_ms) or a register write (idx, val).
    // Hand-typed expectations only where typed is set.
    typedef struct {
        t_row_kind                   kind;
        logic [pdrs_pkg::IDX_W-1:0]  idx;
        logic [31:0]                 val;
        bit                          typed;
        logic [pdrs_pkg::TOP_W-1:0]  cmp;
        logic [pdrs_pkg::DUTY_W-1:0] duty;
        pdrs_pkg::t_phase            ph;
        logic                        upd;
    } t_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [31:0] i_s_tdata   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [31:0] o_m_tdata;  // [15:0] compare_value, [22:16] duty_percent,
                             // [24:23] phase, [25] compare_updated, [31:26] zero

    pwm_duty_ramp_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the registers and the ramp state
    pdrs_pkg::t_cfg   ramp_cfg;
    pdrs_pkg::t_phase ramp_ph;
    logic [31:0]      last_event;
    logic [6:0]       duty_cur;

    t_duty_res   pending_duty[$];
    int          bad_beats = 0;
    bit          src_idle  = 1'b1;
    bit          snk_idle  = 1'b1;

    t_row script [N_ROWS];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #2_000_000;
        $display("FAIL pwm_duty_ramp_sequencer");
        $finish;
    end

    // Advance the ramp by one timestamp and return the beat it should produce
    function automatic t_duty_res advance_ramp(input logic [31:0] now_ms);
        logic [31:0]                 elapsed;
        int                          sum;
        int                          diff;
        logic [pdrs_pkg::DUTY_W-1:0] sat;
        longint unsigned             prod;
        t_duty_res                   r;
        elapsed = now_ms - last_event;  // wraps mod 2^32
        r.upd   = 1'b0;
        case (ramp_ph)
            pdrs_pkg::PH_DWELL: begin
                // end of dwell moves the phase and restarts the timer, duty untouched
                if (elapsed >= ramp_cfg.dwell_ms) begin
                    ramp_ph    = pdrs_pkg::PH_UP;
                    last_event = now_ms;
                end
            end
            pdrs_pkg::PH_UP: begin
                if (elapsed >= ramp_cfg.step_ivl_ms) begin
                    sum        = int'(duty_cur) + int'(ramp_cfg.step_size);
                    last_event = now_ms;
                    r.upd      = 1'b1;
                    // clamps to duty_high even if that is below the current duty
                    if (sum >= int'(ramp_cfg.duty_high)) begin
                        duty_cur = ramp_cfg.duty_high;
                        ramp_ph  = pdrs_pkg::PH_DOWN;
                    end else begin
                        duty_cur = 7'(sum);
                    end
                end
            end
            default: begin
                if (elapsed >= ramp_cfg.step_ivl_ms) begin
                    // signed difference: a big step goes negative and lands on the floor
                    diff       = int'(duty_cur) - int'(ramp_cfg.step_size);
                    last_event = now_ms;
                    r.upd      = 1'b1;
                    if (diff <= int'(ramp_cfg.duty_low)) begin
                        duty_cur = ramp_cfg.duty_low;
                        ramp_ph  = pdrs_pkg::PH_DWELL;
                    end else begin
                        duty_cur = 7'(diff);
                    end
                end
            end
        endcase
        // duty saturated at 100 for the compare only; full scale clips to 16 bits
        sat   = (duty_cur > pdrs_pkg::DUTY_SAT) ? pdrs_pkg::DUTY_SAT : duty_cur;
        prod  = (64'(sat) * (64'(ramp_cfg.period_top) + 64'd1)) / 64'd100;
        r.cmp = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
        r.duty = duty_cur;
        r.ph   = ramp_ph;
        return r;
    endfunction

    task automatic cfg_write(input logic [pdrs_pkg::IDX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            pdrs_pkg::CFG_DUTY_LOW:   ramp_cfg.duty_low    = data[pdrs_pkg::DUTY_W-1:0];
            pdrs_pkg::CFG_DUTY_HIGH:  ramp_cfg.duty_high   = data[pdrs_pkg::DUTY_W-1:0];
            pdrs_pkg::CFG_STEP_SIZE:  ramp_cfg.step_size   = data[pdrs_pkg::DUTY_W-1:0];
            pdrs_pkg::CFG_DWELL_MS:   ramp_cfg.dwell_ms    = data;
            pdrs_pkg::CFG_STEP_IVL:   ramp_cfg.step_ivl_ms = data;
            pdrs_pkg::CFG_PERIOD_TOP: ramp_cfg.period_top  = data[pdrs_pkg::TOP_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one timestamp beat; tvalid stays high afterwards so a
    // zero-gap successor follows back to back
    task automatic send_now(input logic [31:0] now_ms);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= now_ms;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_duty.push_back(advance_ramp(now_ms));
    endtask

    // Stop offering and let every outstanding beat come out
    task automatic drain_pipe();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_duty.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic check_beat(input logic [31:0] beat);
        t_duty_res got;
        t_duty_res want;
        got.cmp  = beat[15:0];
        got.duty = beat[22:16];
        got.ph   = pdrs_pkg::t_phase'(beat[24:23]);
        got.upd  = beat[25];
        if (pending_duty.size() == 0) begin
            bad_beats++;
            if (bad_beats <= MAX_SHOWN)
                $display("unexpected result beat %h at %0t", beat, $realtime);
        end else begin
            want = pending_duty.pop_front();
            if (got !== want) begin
                bad_beats++;
                if (bad_beats <= MAX_SHOWN)
                    $display("mismatch at %0t: cmp %0d/%0d duty %0d/%0d ph %0d/%0d upd %0b/%0b",
                             $realtime, want.cmp, got.cmp, want.duty, got.duty,
                             want.ph, got.ph, want.upd, got.upd);
            end
        end
    endtask

    // Result side: random stall before each beat while snk_idle is set, check on handshake
    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = snk_idle ? $urandom_range(0, MAX_GAP) : 0;
            @(negedge i_clk);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            check_beat(o_m_tdata);
        end
    end

    initial begin : stimulus
        logic [31:0] now_ms;
        logic [31:0] thr;
        logic [6:0]  v7;
        logic [31:0] v32;

        // Directed script. Reset defaults: low 12, high 48, step 5,
        // dwell 5000, interval 1000, top 33332. idx is unused on beat rows.
        script = '{
            // dwell holds until 5000 ms have passed, then turns to ramp up, no update
            '{ROW_BEAT,  NO_IDX, 32'd0,         1'b1, 16'd3999, 7'd12, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd4999,      1'b1, 16'd3999, 7'd12, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd5000,      1'b1, 16'd3999, 7'd12, PHS_UP,    1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd5999,      1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd6000,      1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'hFFFF_FFFF, 1'b0, '0, '0, PHS_DWELL, 1'b0},
            // step 100 (junk above bit 6): overshoots the top, then undershoots negative
            '{ROW_WRITE, pdrs_pkg::CFG_STEP_SIZE,  32'hFFFF_FFE4, 1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd1000,      1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd2000,      1'b1, 16'd3999, 7'd12, PHS_DWELL, 1'b1},
            // inverted limits, zero timers, full-scale top
            '{ROW_WRITE, pdrs_pkg::CFG_DUTY_LOW,   32'd127,       1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, pdrs_pkg::CFG_DUTY_HIGH,  32'd0,         1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, pdrs_pkg::CFG_DWELL_MS,   32'd0,         1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, pdrs_pkg::CFG_STEP_IVL,   32'd0,         1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, pdrs_pkg::CFG_PERIOD_TOP, 32'h0000_FFFF, 1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd2000,      1'b0, '0, '0, PHS_DWELL, 1'b0},
            // ramp up clamps down to a top below the current duty
            '{ROW_BEAT,  NO_IDX, 32'd2000,      1'b1, 16'd0, 7'd0, PHS_DOWN, 1'b1},
            // floor above 100: compare saturates, product overflow clips
            '{ROW_BEAT,  NO_IDX, 32'd2000,      1'b1, 16'hFFFF, 7'd127, PHS_DWELL, 1'b1},
            '{ROW_WRITE, pdrs_pkg::CFG_DUTY_LOW,   32'd0,         1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, pdrs_pkg::CFG_STEP_SIZE,  32'd0,         1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, pdrs_pkg::CFG_DUTY_HIGH,  32'hAAAA_AAFF, 1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd2001,      1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd2001,      1'b0, '0, '0, PHS_DWELL, 1'b0},
            // top 0: full duty gives compare 1; zero step keeps ramping down in place
            '{ROW_WRITE, pdrs_pkg::CFG_PERIOD_TOP, 32'h5555_0000, 1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd2001,      1'b1, 16'd1, 7'd127, PHS_DOWN, 1'b1},
            // writes to unmapped indexes leave everything alone; both timers then go to their maximum
            '{ROW_WRITE, CFG_BAD_6,                32'hFFFF_FFFF, 1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, CFG_BAD_7,                32'd0,         1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, pdrs_pkg::CFG_DWELL_MS,   32'hFFFF_FFFF, 1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_WRITE, pdrs_pkg::CFG_STEP_IVL,   32'hFFFF_FFFF, 1'b0, '0, '0, PHS_DWELL, 1'b0},
            '{ROW_BEAT,  NO_IDX, 32'd2001,      1'b1, 16'd1, 7'd127, PHS_DOWN, 1'b0},
            // going back 1 ms is the largest elapsed time, just reaches the max interval
            '{ROW_BEAT,  NO_IDX, 32'd2000,      1'b0, '0, '0, PHS_DWELL, 1'b0}
        };

        ramp_cfg = '{pdrs_pkg::RST_DUTY_LOW, pdrs_pkg::RST_DUTY_HIGH,
                     pdrs_pkg::RST_STEP_SIZE, pdrs_pkg::RST_DWELL_MS,
                     pdrs_pkg::RST_STEP_IVL, pdrs_pkg::RST_PERIOD_TOP};
        ramp_ph    = pdrs_pkg::PH_DWELL;
        last_event = '0;
        duty_cur   = pdrs_pkg::RST_DUTY_LOW;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[r]) begin
            if (script[r].kind == ROW_WRITE) begin
                drain_pipe();
                cfg_write(script[r].idx, script[r].val);
            end else begin
                send_now(script[r].val);
                // replace the predicted beat with the hand-read one
                if (script[r].typed)
                    pending_duty[pending_duty.size()-1] =
                        '{script[r].cmp, script[r].duty, script[r].ph, script[r].upd};
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_pipe();
            src_idle = $urandom_range(0, 3) != 0;
            snk_idle = $urandom_range(0, 3) != 0;

            // fresh settings: edge values now and then, junk in the unused data bits
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0: v7 = 7'd0;
                    1: v7 = 7'd100;
                    2: v7 = 7'd127;
                    default: v7 = 7'($urandom_range(0, 40));
                endcase
                cfg_write(pdrs_pkg::CFG_DUTY_LOW, {25'($urandom()), v7});
            end
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0: v7 = 7'd0;
                    1: v7 = 7'd100;
                    2: v7 = 7'd127;
                    default: v7 = 7'($urandom_range(40, 100));
                endcase
                cfg_write(pdrs_pkg::CFG_DUTY_HIGH, {25'($urandom()), v7});
            end
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0: v7 = 7'd0;
                    1: v7 = 7'd100;
                    2: v7 = 7'd127;
                    default: v7 = 7'($urandom_range(1, 25));
                endcase
                cfg_write(pdrs_pkg::CFG_STEP_SIZE, {25'($urandom()), v7});
            end
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0: v32 = 32'd0;
                    1: v32 = 32'hFFFF_FFFF;
                    2: v32 = $urandom();
                    default: v32 = $urandom_range(0, 1500);
                endcase
                cfg_write(pdrs_pkg::CFG_DWELL_MS, v32);
            end
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0: v32 = 32'd0;
                    1: v32 = 32'hFFFF_FFFF;
                    2: v32 = $urandom();
                    default: v32 = $urandom_range(0, 1500);
                endcase
                cfg_write(pdrs_pkg::CFG_STEP_IVL, v32);
            end
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 5))
                    0: v32 = {16'($urandom()), 16'h0000};
                    1: v32 = {16'($urandom()), 16'hFFFF};
                    default: v32 = $urandom();
                endcase
                cfg_write(pdrs_pkg::CFG_PERIOD_TOP, v32);
            end
            if ($urandom_range(0, 3) == 0)
                cfg_write(($urandom_range(0, 1) != 0) ? CFG_BAD_6 : CFG_BAD_7, $urandom());

            // timestamps aimed around the next event so the ramp keeps moving;
            // some noise and some backward jumps mixed in
            repeat (PER_PHASE) begin
                thr = (ramp_ph == pdrs_pkg::PH_DWELL) ? ramp_cfg.dwell_ms
                                                      : ramp_cfg.step_ivl_ms;
                case ($urandom_range(0, 9))
                    0:          now_ms = $urandom();
                    1:          now_ms = last_event + thr - 32'd1;
                    2, 3:       now_ms = last_event + thr;
                    4, 5, 6, 7: now_ms = last_event + thr + 32'($urandom_range(0, 3));
                    8:          now_ms = last_event + 32'($urandom_range(0, 7));
                    default:    now_ms = last_event - 32'd1;
                endcase
                send_now(now_ms);
            end
        end

        drain_pipe();
        if (bad_beats == 0)
            $display("PASS pwm_duty_ramp_sequencer");
        else
            $display("FAIL pwm_duty_ramp_sequencer");
        $finish;
    end

endmodule
